// ----- rtl/i2cbm_pkg.sv -----
`default_nettype none

package i2cbm_pkg;

	// Bus timing register
	localparam int HPT_W            = 16;
	localparam logic [HPT_W-1:0] HPT_RESET = 16'd5;
	localparam int DELAY_W_DEFAULT  = 16;

	// Stream payload widths
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 16;

	// Request codes carried on tuser
	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_START = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_WRITE = 3'd3,
		REQ_READ  = 3'd4
	} req_t;

	// Running operation of the sequencer
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// One request as held in the input stage
	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       sda_in;
		logic       scl_in;
	} item_t;

	// One result as produced by the sequencer
	typedef struct packed {
		logic       rejected;
		logic       ack_level;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive_low;
		logic       scl_drive_low;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_bus_master_unit.sv -----
// A request is held in the input stage, and its result then in the result register.
// One request per cycle while results drain; a held result stalls the full input stage.
// Ready on the request side follows m_tready combinationally through the input stage.
// Reset: sequencer idle, both lines released, counters and shift register zero,
// half period register back to 5 ticks.
`default_nettype none

module i2c_bus_master_unit import i2cbm_pkg::*; #(
	parameter int DELAY_COUNTER_WIDTH = DELAY_W_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// tdata: data_byte[7:0], send_ack[8], sda_in[9], scl_in[10], zero[15:11]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// tuser: req_type[2:0]
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// tdata: scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3],
	// rx_byte[11:4], ack_level[12], rejected[13], zero[15:14]
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [HPT_W-1:0]       cfg_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready
);

	logic             hpt_q;
	logic [HPT_W-1:0] half_period_q;
	item_t            item_s1;
	logic             valid_s1;
	logic             adv_s1;
	result_t          res;

	assign cfg_ready = 1'b1;

	// Half period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HPT_RESET;
			hpt_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			half_period_q <= cfg_data;
			hpt_q         <= 1'b1;
		end
	end

	// Advance the input stage when the result register is free or drained
	assign adv_s1   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type  <= s_tuser[2:0];
			item_s1.data_byte <= s_tdata[7:0];
			item_s1.send_ack  <= s_tdata[8];
			item_s1.sda_in    <= s_tdata[9];
			item_s1.scl_in    <= s_tdata[10];
		end
	end

	i2cbm_seq #(
		.DELAY_COUNTER_WIDTH(DELAY_COUNTER_WIDTH)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (adv_s1),
		.item             (item_s1),
		.half_period_ticks(half_period_q),
		.result           (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tdata <= {2'b00, res.rejected, res.ack_level, res.rx_byte, res.done_res,
				res.busy_res, res.sda_drive_low, res.scl_drive_low};
		end
	end

	// A refused request leaves the running operation in place
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[13]) |-> (m_tdata[2] && !m_tdata[3]))
		else $error("refused request without a running operation");

	// Completion drops busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> !m_tdata[2])
		else $error("done reported while still busy");

	// Received byte and acknowledge level only appear on completion
	a_rx_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[3]) |-> (m_tdata[11:4] == 8'd0 && !m_tdata[12]))
		else $error("receive data outside completion");

	// The configuration write stays visible in the timing register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (half_period_q == $past(cfg_data) && hpt_q))
		else $error("half period register missed a write");

endmodule

`default_nettype wire

// ----- rtl/i2cbm_seq.sv -----
`default_nettype none

module i2cbm_seq import i2cbm_pkg::*; #(
	parameter int DELAY_COUNTER_WIDTH = DELAY_W_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire item_t            item,
	input  wire logic [HPT_W-1:0] half_period_ticks,
	output result_t               result
);

	localparam int DW = DELAY_COUNTER_WIDTH;
	localparam int LW = (DW > HPT_W) ? DW : HPT_W;

	op_t          op_q, op_n;
	logic [2:0]   phase_q, phase_n;
	logic [3:0]   bit_q, bit_n;
	logic [7:0]   shift_q, shift_n;
	logic [DW-1:0] delay_q, delay_n;
	logic         clk_pull_q, clk_pull_n;
	logic         dat_pull_q, dat_pull_n;
	logic         ack_choice_q, ack_choice_n;
	logic         ack_seen_q, ack_seen_n;
	logic         done, rej;
	logic [7:0]   rx;
	logic         ackl;
	logic         is_cmd;

	logic [LW-1:0] load_ext;
	logic [LW-1:0] max_ext;
	logic [DW-1:0] load_val;

	// Delay reload: zero counts as one, saturate to the counter range
	always_comb begin
		load_ext = LW'((half_period_ticks == '0) ? HPT_W'(1) : half_period_ticks);
		max_ext  = LW'({DW{1'b1}});
		load_val = (load_ext > max_ext) ? DW'(max_ext) : DW'(load_ext);
	end

	// Decode command requests
	always_comb begin
		case (item.req_type) inside
			REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: is_cmd = 1'b1;
			default:                                  is_cmd = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		op_n         = op_q;
		phase_n      = phase_q;
		bit_n        = bit_q;
		shift_n      = shift_q;
		delay_n      = delay_q;
		clk_pull_n   = clk_pull_q;
		dat_pull_n   = dat_pull_q;
		ack_choice_n = ack_choice_q;
		ack_seen_n   = ack_seen_q;
		done         = 1'b0;
		rej          = 1'b0;
		rx           = '0;
		ackl         = 1'b0;

		if (is_cmd) begin
			if (op_q != OP_IDLE) begin
				rej = 1'b1;
			end else begin
				op_n       = op_t'(item.req_type);
				phase_n    = '0;
				bit_n      = '0;
				clk_pull_n = 1'b0;
				unique case (req_t'(item.req_type))
					REQ_START: begin
						dat_pull_n = 1'b0;
						delay_n    = load_val;
					end
					REQ_STOP: begin
						dat_pull_n = 1'b1;
						delay_n    = load_val;
					end
					REQ_WRITE: begin
						shift_n    = item.data_byte;
						dat_pull_n = ~|(item.data_byte & MSB_MASK);
						delay_n    = load_val;
					end
					default: begin
						shift_n      = '0;
						ack_choice_n = item.send_ack;
						dat_pull_n   = 1'b0;
						delay_n      = '0;
					end
				endcase
			end
		end else if (op_q != OP_IDLE) begin
			if (op_q == OP_READ && phase_q == 3'd0) begin
				// Hold until the clock line is seen released
				if (item.scl_in) begin
					phase_n = 3'd1;
					delay_n = load_val;
				end
			end else if (delay_q > DW'(1)) begin
				delay_n = delay_q - DW'(1);
			end else begin
				delay_n = '0;
				unique case (op_q)
					OP_START: begin
						if (phase_q == 3'd0) begin
							dat_pull_n = 1'b1;
							phase_n    = 3'd1;
							delay_n    = load_val;
						end else if (phase_q == 3'd1) begin
							clk_pull_n = 1'b1;
							phase_n    = 3'd2;
							delay_n    = load_val;
						end else begin
							done = 1'b1;
						end
					end
					OP_STOP: begin
						if (phase_q == 3'd0) begin
							dat_pull_n = 1'b0;
							phase_n    = 3'd1;
							delay_n    = load_val;
						end else begin
							done = 1'b1;
						end
					end
					OP_WRITE: begin
						if (phase_q == 3'd0) begin
							clk_pull_n = 1'b1;
							phase_n    = 3'd1;
							delay_n    = load_val;
						end else if (phase_q == 3'd1) begin
							// Shift the next bit out, or release for acknowledge
							shift_n    = {shift_q[6:0], 1'b0};
							bit_n      = bit_q + 4'd1;
							clk_pull_n = 1'b0;
							delay_n    = load_val;
							if (bit_n < BITS_PER_BYTE) begin
								dat_pull_n = ~shift_q[6];
								phase_n    = 3'd0;
							end else begin
								dat_pull_n = 1'b0;
								phase_n    = 3'd2;
							end
						end else if (phase_q == 3'd2) begin
							ack_seen_n = item.sda_in;
							clk_pull_n = 1'b1;
							phase_n    = 3'd3;
							delay_n    = load_val;
						end else begin
							done = 1'b1;
						end
					end
					OP_READ: begin
						if (phase_q == 3'd1) begin
							shift_n    = {shift_q[6:0], item.sda_in};
							clk_pull_n = 1'b1;
							phase_n    = 3'd2;
							delay_n    = load_val;
						end else if (phase_q == 3'd2) begin
							bit_n      = bit_q + 4'd1;
							clk_pull_n = 1'b0;
							if (bit_n < BITS_PER_BYTE) begin
								phase_n = 3'd0;
							end else begin
								dat_pull_n = ack_choice_q;
								phase_n    = 3'd3;
								delay_n    = load_val;
							end
						end else if (phase_q == 3'd3) begin
							clk_pull_n = 1'b1;
							phase_n    = 3'd4;
							delay_n    = load_val;
						end else begin
							done = 1'b1;
						end
					end
					default: done = 1'b1;
				endcase
				if (done) begin
					rx      = (op_q == OP_READ) ? shift_q : 8'd0;
					ackl    = (op_q == OP_WRITE) ? ack_seen_q : 1'b0;
					op_n    = OP_IDLE;
					phase_n = '0;
				end
			end
		end
	end

	// Result fields
	always_comb begin
		result.scl_drive_low = clk_pull_n;
		result.sda_drive_low = dat_pull_n;
		result.busy_res      = (op_n != OP_IDLE);
		result.done_res      = done;
		result.rx_byte       = rx;
		result.ack_level     = ackl;
		result.rejected      = rej;
	end

	// Commit state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_IDLE;
			phase_q      <= '0;
			bit_q        <= '0;
			shift_q      <= '0;
			delay_q      <= '0;
			clk_pull_q   <= 1'b0;
			dat_pull_q   <= 1'b0;
			ack_choice_q <= 1'b0;
			ack_seen_q   <= 1'b0;
		end else if (step) begin
			op_q         <= op_n;
			phase_q      <= phase_n;
			bit_q        <= bit_n;
			shift_q      <= shift_n;
			delay_q      <= delay_n;
			clk_pull_q   <= clk_pull_n;
			dat_pull_q   <= dat_pull_n;
			ack_choice_q <= ack_choice_n;
			ack_seen_q   <= ack_seen_n;
		end
	end

endmodule

`default_nettype wire
